/* rtl/hbq_pkg.sv */
// shared types, field widths and codes for the histogram quantile unit
package hbq_pkg;

    localparam int BOUND_W   = 48;
    localparam int COUNT_W   = 48;
    localparam int Q_W       = 32;
    localparam int MCAND_W   = BOUND_W + 1;
    localparam int PROD_W    = MCAND_W + COUNT_W;
    localparam int MUL_STEPS = COUNT_W;
    localparam int DIV_STEPS = PROD_W;

    // bound kinds on the input side
    localparam logic [1:0] KIND_FIN  = 2'd0;
    localparam logic [1:0] KIND_PINF = 2'd1;
    localparam logic [1:0] KIND_MINF = 2'd2;
    localparam logic [1:0] KIND_NAN  = 2'd3;

    // result kinds
    localparam logic [2:0] OUT_FIN  = 3'd0;
    localparam logic [2:0] OUT_NAN  = 3'd1;
    localparam logic [2:0] OUT_PINF = 3'd2;
    localparam logic [2:0] OUT_MINF = 3'd3;
    localparam logic [2:0] OUT_OVF  = 3'd4;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_MOVE = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic [1:0]                 kind;
        logic signed [BOUND_W-1:0]  bound;
        logic [COUNT_W-1:0]         count;
    } cell_data_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ins_en;
        logic       add_en;
    } cell_ctrl_t;

    // minus inf sorts first, plus inf last
    function automatic logic [1:0] kind_order(input logic [1:0] kind);
        logic [1:0] ord;
        case (kind)
            KIND_MINF: ord = 2'd0;
            KIND_FIN:  ord = 2'd1;
            default:   ord = 2'd2;
        endcase
        return ord;
    endfunction

endpackage

/* rtl/hbq_cell.sv */
// one sorted bucket cell: compares with the incoming bucket, merges or shifts
module hbq_cell
    import hbq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  cell_data_t new_item,
    input  cell_data_t left_item,
    input  cell_data_t right_item,
    input  logic       prev_ge,
    output cell_data_t item,
    output logic       ge,
    output logic       eq
);

    logic                      valid_reg, valid_next;
    logic [1:0]                kind_reg, kind_next;
    logic signed [BOUND_W-1:0] bound_reg, bound_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COUNT_W:0]          sum;
    logic [1:0]                ord_c, ord_n;

    assign ord_c = kind_order(kind_reg);
    assign ord_n = kind_order(new_item.kind);
    assign sum   = {1'b0, count_reg} + {1'b0, new_item.count};

    assign eq = valid_reg && (ord_c == ord_n)
                && ((kind_reg != KIND_FIN) || (bound_reg == new_item.bound));
    // empty cells count as above everything
    assign ge = !valid_reg || (ord_c > ord_n)
                || ((ord_c == ord_n)
                    && ((kind_reg != KIND_FIN) || (bound_reg >= new_item.bound)));

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        bound_next = bound_reg;
        count_next = count_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (ctrl.add_en && eq) begin
                    count_next = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
                end
                if (ctrl.ins_en && ge) begin
                    if (!prev_ge) begin
                        valid_next = 1'b1;
                        kind_next  = new_item.kind;
                        bound_next = new_item.bound;
                        count_next = new_item.count;
                    end else begin
                        valid_next = left_item.valid;
                        kind_next  = left_item.kind;
                        bound_next = left_item.bound;
                        count_next = left_item.count;
                    end
                end
            end
            CELL_MOVE: begin
                valid_next = right_item.valid;
                kind_next  = right_item.kind;
                bound_next = right_item.bound;
                count_next = right_item.count;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        kind_reg  <= kind_next;
        bound_reg <= bound_next;
        count_reg <= count_next;
    end

    assign item = '{valid: valid_reg, kind: kind_reg, bound: bound_reg, count: count_reg};

endmodule

/* rtl/hbq_muldiv.sv */
// bit-serial shift-add multiplier and restoring divider sharing one accumulator
module hbq_muldiv
    import hbq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start_mul,
    input  logic               start_div,
    input  logic [MCAND_W-1:0] mcand,
    input  logic [COUNT_W-1:0] mplier,
    input  logic [COUNT_W-1:0] den,
    output logic               done,
    output logic [PROD_W-1:0]  prod,
    output logic [COUNT_W-1:0] quo
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic               mul_busy_reg, mul_busy_next;
    logic               div_busy_reg, div_busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [COUNT_W-1:0] mplier_reg, mplier_next;
    logic [COUNT_W-1:0] den_reg, den_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [COUNT_W:0]   trial;

    assign trial = {rem_reg, acc_reg[PROD_W-1]};

    always_comb begin
        mul_busy_next = mul_busy_reg;
        div_busy_next = div_busy_reg;
        done_next     = 1'b0;
        step_next     = step_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        if (start_mul) begin
            mul_busy_next = 1'b1;
            step_next     = '0;
            acc_next      = '0;
            mcand_next    = mcand;
            mplier_next   = mplier;
        end else if (start_div) begin
            div_busy_next = 1'b1;
            step_next     = '0;
            den_next      = den;
            rem_next      = '0;
            quo_next      = '0;
        end else if (mul_busy_reg) begin
            // msb first: shift the partial product, add the multiplicand
            acc_next    = {acc_reg[PROD_W-2:0], 1'b0}
                          + (mplier_reg[COUNT_W-1] ? PROD_W'(mcand_reg) : '0);
            mplier_next = {mplier_reg[COUNT_W-2:0], 1'b0};
            step_next   = step_reg + 1'b1;
            if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                mul_busy_next = 1'b0;
                done_next     = 1'b1;
            end
        end else if (div_busy_reg) begin
            acc_next  = {acc_reg[PROD_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = COUNT_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[COUNT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COUNT_W-1:0];
                quo_next = {quo_reg[COUNT_W-2:0], 1'b0};
            end
            if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                div_busy_next = 1'b0;
                done_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            mul_busy_reg <= mul_busy_next;
            div_busy_reg <= div_busy_next;
            done_reg     <= done_next;
        end
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/histogram_bucket_quantile_unit.sv */
// top level of the histogram quantile unit: bucket cell chain, sequencer, result register
//
// usage
// - input stream (s_*): one histogram bucket per transfer, s_tlast on the final
//   transfer of a histogram; the quantile fields are read only on that transfer
// - a non-last transfer is absorbed without an evaluation: every cell compares its bound
//   with the new one at once, then the matching cell adds the count or the chain
//   opens a gap and the new bucket drops into sorted position
// - on a last transfer s_tready drops while the unit evaluates:
//   a rotate pass over MAX_BUCKETS cells (count, total, top kind), a serial
//   multiply for the rank, a shift-out pass over MAX_BUCKETS cells that
//   finds the bucket and empties the chain, then when interpolating a serial
//   multiply and a restoring divide
// - output stream (m_*): one result per histogram, held in an output register;
//   if the receiver stalls the unit waits with the finished result and takes no
//   new bucket until the older result is taken, while non-last buckets keep
//   flowing as long as no evaluation is pending
// - reset empties the chain and clears the error flags; no result is pending
module histogram_bucket_quantile_unit
    import hbq_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // bound[47:0], bucket_count[95:48], quantile[127:96]
    input  logic [3:0]   s_tuser,   // bucket_present[0], bound_kind[2:1], quantile_is_nan[3]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // value[47:0]
    output logic [2:0]   m_tuser    // value_kind[2:0]
);

    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
    localparam logic signed [33:0] Q_ONE = 34'(64'd1 << FRAC_BITS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ROTATE = 4'd1;
    localparam logic [3:0] ST_QGO    = 4'd2;
    localparam logic [3:0] ST_QWAIT  = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_WGO    = 4'd6;
    localparam logic [3:0] ST_WWAIT  = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // input fields
    logic                      in_present, in_qnan;
    logic [1:0]                in_kind;
    logic signed [BOUND_W-1:0] in_bound;
    logic [COUNT_W-1:0]        in_count;
    logic signed [Q_W-1:0]     in_q;
    logic                      in_xfer;

    assign in_bound   = s_tdata[47:0];
    assign in_count   = s_tdata[95:48];
    assign in_q       = s_tdata[127:96];
    assign in_present = s_tuser[0];
    assign in_kind    = s_tuser[2:1];
    assign in_qnan    = s_tuser[3];
    assign in_xfer    = s_tvalid && s_tready;

    // cell chain
    cell_data_t              cell_q [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0]  cell_ge, cell_eq;
    cell_ctrl_t              ctrl;
    cell_data_t              new_item, empty_item, top_feed;
    logic                    any_eq, chain_full, real_bucket;

    logic [3:0]                state_reg, state_next;
    logic [IDX_W-1:0]          pass_reg, pass_next;
    logic                      saw_nan_reg, saw_nan_next;
    logic                      too_many_reg, too_many_next;
    logic signed [Q_W-1:0]     q_reg, q_next;
    logic                      qnan_reg, qnan_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [COUNT_W-1:0]        total_reg, total_next;
    logic [1:0]                top_kind_reg, top_kind_next;
    logic [COUNT_W-1:0]        rank_reg, rank_next;
    logic [COUNT_W-1:0]        run_reg, run_next;
    logic                      found_reg, found_next;
    logic                      b_zero_reg, b_zero_next;
    logic [1:0]                prv_kind_reg, prv_kind_next;
    logic signed [BOUND_W-1:0] prv_bound_reg, prv_bound_next;
    logic [1:0]                start_kind_reg, start_kind_next;
    logic signed [BOUND_W-1:0] start_reg, start_next;
    logic [COUNT_W-1:0]        base_cnt_reg, base_cnt_next;
    logic [1:0]                end_kind_reg, end_kind_next;
    logic signed [BOUND_W-1:0] end_reg, end_next;
    logic [COUNT_W-1:0]        end_cnt_reg, end_cnt_next;
    logic [1:0]                sec_kind_reg, sec_kind_next;
    logic signed [BOUND_W-1:0] sec_bound_reg, sec_bound_next;
    logic                      m_valid_reg, m_valid_next;
    logic [2:0]                res_kind_reg, res_kind_next;
    logic [BOUND_W-1:0]        res_val_reg, res_val_next;
    // output register, loaded only when the result is handed to the m_ side
    logic [2:0]                out_kind_reg, out_kind_next;
    logic [BOUND_W-1:0]        out_val_reg, out_val_next;

    // serial arithmetic unit
    logic               md_start_mul, md_start_div, md_done;
    logic [MCAND_W-1:0] md_mcand;
    logic [COUNT_W-1:0] md_mplier, md_den, md_quo;
    logic [PROD_W-1:0]  md_prod;

    cell_data_t         head;
    logic [COUNT_W-1:0] scan_run, den_val, num_val;
    logic               in_range, at_top;

    assign real_bucket = in_present && (in_kind != KIND_NAN);
    assign any_eq      = |cell_eq;
    assign chain_full  = cell_q[MAX_BUCKETS-1].valid;
    // infinite bounds store zero bits so they compare equal among themselves
    assign new_item    = '{valid: 1'b1, kind: in_kind,
                           bound: (in_kind == KIND_FIN) ? in_bound : '0,
                           count: in_count};
    assign empty_item  = '{valid: 1'b0, kind: KIND_FIN, bound: '0, count: '0};
    assign top_feed    = (state_reg == ST_ROTATE) ? cell_q[0] : empty_item;

    always_comb begin
        ctrl = '{op: CELL_HOLD, ins_en: 1'b0, add_en: 1'b0};
        if (in_xfer && real_bucket) begin
            ctrl.op     = CELL_INS;
            ctrl.add_en = 1'b1;
            ctrl.ins_en = !any_eq && !chain_full;
        end else if (state_reg == ST_ROTATE || state_reg == ST_SCAN) begin
            ctrl.op = CELL_MOVE;
        end
    end

    for (genvar gi = 0; gi < MAX_BUCKETS; gi++) begin : g_cell
        hbq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_item   (new_item),
            .left_item  ((gi == 0) ? new_item : cell_q[(gi == 0) ? 0 : gi - 1]),
            .right_item ((gi == MAX_BUCKETS - 1) ? top_feed
                                                 : cell_q[(gi == MAX_BUCKETS - 1) ? gi : gi + 1]),
            .prev_ge    ((gi == 0) ? 1'b0 : cell_ge[(gi == 0) ? 0 : gi - 1]),
            .item       (cell_q[gi]),
            .ge         (cell_ge[gi]),
            .eq         (cell_eq[gi])
        );
    end

    hbq_muldiv u_muldiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_mul (md_start_mul),
        .start_div (md_start_div),
        .mcand     (md_mcand),
        .mplier    (md_mplier),
        .den       (md_den),
        .done      (md_done),
        .prod      (md_prod),
        .quo       (md_quo)
    );

    // scan helpers: the chain head is bucket number pass_reg
    assign head     = cell_q[0];
    assign in_range = CNT_W'(pass_reg) < n_reg;
    assign at_top   = CNT_W'(pass_reg) == (n_reg - 1'b1);
    assign scan_run = (pass_reg == '0 || head.count > run_reg) ? head.count : run_reg;
    assign den_val  = end_cnt_reg - base_cnt_reg;
    assign num_val  = rank_reg - base_cnt_reg;

    always_comb begin
        md_start_mul = 1'b0;
        md_start_div = 1'b0;
        md_mcand     = MCAND_W'(total_reg);
        md_mplier    = COUNT_W'({1'b0, q_reg[Q_W-2:0]});
        md_den       = den_val;
        if (state_reg == ST_QGO) begin
            md_start_mul = 1'b1;
        end else if (state_reg == ST_WGO) begin
            md_start_mul = 1'b1;
            md_mcand     = MCAND_W'({end_reg[BOUND_W-1], end_reg}
                                    - {start_reg[BOUND_W-1], start_reg});
            md_mplier    = num_val;
        end else if (state_reg == ST_WWAIT && md_done) begin
            md_start_div = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        saw_nan_next    = saw_nan_reg;
        too_many_next   = too_many_reg;
        q_next          = q_reg;
        qnan_next       = qnan_reg;
        n_next          = n_reg;
        total_next      = total_reg;
        top_kind_next   = top_kind_reg;
        rank_next       = rank_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        b_zero_next     = b_zero_reg;
        prv_kind_next   = prv_kind_reg;
        prv_bound_next  = prv_bound_reg;
        start_kind_next = start_kind_reg;
        start_next      = start_reg;
        base_cnt_next   = base_cnt_reg;
        end_kind_next   = end_kind_reg;
        end_next        = end_reg;
        end_cnt_next    = end_cnt_reg;
        sec_kind_next   = sec_kind_reg;
        sec_bound_next  = sec_bound_reg;
        res_kind_next   = res_kind_reg;
        res_val_next    = res_val_reg;
        out_kind_next   = out_kind_reg;
        out_val_next    = out_val_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (in_present && in_kind == KIND_NAN) begin
                        saw_nan_next = 1'b1;
                    end
                    if (real_bucket && !any_eq && chain_full) begin
                        too_many_next = 1'b1;
                    end
                    if (s_tlast) begin
                        q_next     = in_q;
                        qnan_next  = in_qnan;
                        n_next     = '0;
                        total_next = '0;
                        pass_next  = '0;
                        state_next = ST_ROTATE;
                    end
                end
            end
            ST_ROTATE: begin
                if (head.valid) begin
                    n_next        = n_reg + 1'b1;
                    top_kind_next = head.kind;
                    if (head.count > total_reg) begin
                        total_next = head.count;
                    end
                end
                pass_next = pass_reg + 1'b1;
                if (pass_reg == IDX_W'(MAX_BUCKETS - 1)) begin
                    pass_next  = '0;
                    state_next = ST_QGO;
                end
            end
            ST_QGO: begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (md_done) begin
                    rank_next     = md_prod[FRAC_BITS +: COUNT_W];
                    found_next    = 1'b0;
                    prv_kind_next = KIND_FIN;
                    prv_bound_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (in_range && !found_reg) begin
                    if (!at_top && scan_run >= rank_reg) begin
                        found_next      = 1'b1;
                        b_zero_next     = (pass_reg == '0);
                        start_kind_next = prv_kind_reg;
                        start_next      = prv_bound_reg;
                        base_cnt_next   = (pass_reg == '0) ? '0 : run_reg;
                        end_kind_next   = head.kind;
                        end_next        = head.bound;
                        end_cnt_next    = scan_run;
                    end else if (at_top) begin
                        sec_kind_next  = prv_kind_reg;
                        sec_bound_next = prv_bound_reg;
                    end
                    prv_kind_next  = head.kind;
                    prv_bound_next = head.bound;
                    run_next       = scan_run;
                end
                pass_next = pass_reg + 1'b1;
                if (pass_reg == IDX_W'(MAX_BUCKETS - 1)) begin
                    pass_next  = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_val_next  = '0;
                res_kind_next = OUT_NAN;
                state_next    = ST_DONE;
                saw_nan_next  = 1'b0;
                too_many_next = 1'b0;
                if (qnan_reg) begin
                    res_kind_next = OUT_NAN;
                end else if (q_reg < 0) begin
                    res_kind_next = OUT_MINF;
                end else if ($signed({{2{q_reg[Q_W-1]}}, q_reg}) > Q_ONE) begin
                    res_kind_next = OUT_PINF;
                end else if (too_many_reg) begin
                    res_kind_next = OUT_OVF;
                end else if (n_reg == '0 || saw_nan_reg || top_kind_reg != KIND_PINF
                             || n_reg < CNT_W'(2) || total_reg == '0) begin
                    res_kind_next = OUT_NAN;
                end else if (!found_reg) begin
                    // rank falls in the top bucket: second highest bound
                    if (sec_kind_reg == KIND_MINF) begin
                        res_kind_next = OUT_MINF;
                    end else if (sec_kind_reg == KIND_PINF) begin
                        res_kind_next = OUT_PINF;
                    end else begin
                        res_kind_next = OUT_FIN;
                        res_val_next  = sec_bound_reg;
                    end
                end else if (b_zero_reg && (end_kind_reg == KIND_MINF || end_reg <= 0)) begin
                    if (end_kind_reg == KIND_MINF) begin
                        res_kind_next = OUT_MINF;
                    end else begin
                        res_kind_next = OUT_FIN;
                        res_val_next  = end_reg;
                    end
                end else if (start_kind_reg != KIND_FIN || den_val == '0) begin
                    res_kind_next = OUT_NAN;
                end else begin
                    state_next = ST_WGO;
                end
            end
            ST_WGO: begin
                state_next = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (md_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (md_done) begin
                    res_kind_next = OUT_FIN;
                    res_val_next  = start_reg + md_quo;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_kind_next = res_kind_reg;
                    out_val_next  = res_val_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_reg     <= '0;
            saw_nan_reg  <= 1'b0;
            too_many_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            saw_nan_reg  <= saw_nan_next;
            too_many_reg <= too_many_next;
            m_valid_reg  <= m_valid_next;
        end
        q_reg          <= q_next;
        qnan_reg       <= qnan_next;
        n_reg          <= n_next;
        total_reg      <= total_next;
        top_kind_reg   <= top_kind_next;
        rank_reg       <= rank_next;
        run_reg        <= run_next;
        found_reg      <= found_next;
        b_zero_reg     <= b_zero_next;
        prv_kind_reg   <= prv_kind_next;
        prv_bound_reg  <= prv_bound_next;
        start_kind_reg <= start_kind_next;
        start_reg      <= start_next;
        base_cnt_reg   <= base_cnt_next;
        end_kind_reg   <= end_kind_next;
        end_reg        <= end_next;
        end_cnt_reg    <= end_cnt_next;
        sec_kind_reg   <= sec_kind_next;
        sec_bound_reg  <= sec_bound_next;
        res_kind_reg   <= res_kind_next;
        res_val_reg    <= res_val_next;
        out_kind_reg   <= out_kind_next;
        out_val_reg    <= out_val_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_kind_reg;

    // a last transfer always starts an evaluation
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tlast) |=> !s_tready)
        else $error("input still ready after a last transfer");

    // an occupied last cell implies an occupied head outside the rotate pass
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROTATE && cell_q[MAX_BUCKETS-1].valid) |-> cell_q[0].valid)
        else $error("bucket chain has a gap");

    // the scan pass leaves the chain empty
    a_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> !cell_q[0].valid)
        else $error("bucket chain not empty after scan");

endmodule

/* verif/histogram_bucket_quantile_unit_tb.sv */
// self-checking testbench for the histogram quantile unit with a scoreboard class
module histogram_bucket_quantile_unit_tb;
    import hbq_pkg::*;

    localparam int NCELLS = 64;
    localparam int FRAC   = 16;
    localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic        present;
        logic [47:0] bound;
        logic [1:0]  kind;
        logic [47:0] count;
        logic [31:0] q;
        logic        q_nan;
        logic        last;
    } bucket_item_t;

    typedef struct {
        logic [47:0] value;
        logic [2:0]  kind;
    } quantile_res_t;

    class quantile_scoreboard;
        logic signed [47:0] bnd[NCELLS];
        logic [1:0]         bkind[NCELLS];
        logic [47:0]        cnt[NCELLS];
        int                 used;
        bit                 nan_seen;
        bit                 ovf;
        quantile_res_t      pending[$];
        int                 errors;
        int                 results;

        function new();
            used = 0; nan_seen = 0; ovf = 0; errors = 0; results = 0;
        endfunction

        static function int rank_of(logic [1:0] k);
            if (k == KIND_MINF) return 0;
            if (k == KIND_FIN) return 1;
            return 2;
        endfunction

        function void insert(logic [1:0] k, logic signed [47:0] b, logic [47:0] c);
            int pos;
            int ra;
            int rb;
            logic [48:0] s;
            pos = 0;
            if (k == KIND_NAN) begin
                nan_seen = 1;
                return;
            end
            if (k != KIND_FIN) b = 0;
            rb = rank_of(k);
            while (pos < used) begin
                ra = rank_of(bkind[pos]);
                if (ra == rb && (k != KIND_FIN || bnd[pos] == b)) begin
                    s = {1'b0, cnt[pos]} + {1'b0, c};
                    cnt[pos] = s[48] ? CNT_MAX : s[47:0];
                    return;
                end
                if (ra > rb || (ra == rb && bnd[pos] > b)) break;
                pos++;
            end
            if (used >= NCELLS) begin
                ovf = 1;
                return;
            end
            for (int j = used; j > pos; j--) begin
                bnd[j] = bnd[j-1]; bkind[j] = bkind[j-1]; cnt[j] = cnt[j-1];
            end
            bnd[pos] = b; bkind[pos] = k; cnt[pos] = c;
            used++;
        endfunction

        function quantile_res_t bound_at(int i);
            quantile_res_t r;
            r.value = 0;
            if (bkind[i] == KIND_MINF) r.kind = OUT_MINF;
            else if (bkind[i] == KIND_PINF) r.kind = OUT_PINF;
            else begin
                r.kind = OUT_FIN;
                r.value = bnd[i];
            end
            return r;
        endfunction

        function quantile_res_t evaluate(logic signed [31:0] q, logic q_nan);
            quantile_res_t r;
            logic [47:0]  run;
            logic [47:0]  total;
            logic [63:0]  rnk;
            logic [79:0]  prod;
            logic [63:0]  prev;
            logic [63:0]  den;
            logic [63:0]  num;
            logic [63:0]  wdt;
            logic [127:0] big;
            logic signed [63:0] start;
            int n;
            int b;
            r.value = 0;
            n = used;
            if (q_nan) begin r.kind = OUT_NAN; return r; end
            if (q < 0) begin r.kind = OUT_MINF; return r; end
            if (q > (32'sd1 <<< FRAC)) begin r.kind = OUT_PINF; return r; end
            if (ovf) begin r.kind = OUT_OVF; return r; end
            r.kind = OUT_NAN;
            if (n == 0 || nan_seen) return r;
            if (bkind[n-1] != KIND_PINF || n < 2) return r;
            run = cnt[0];
            for (int i = 1; i < n; i++) begin
                if (cnt[i] < run) cnt[i] = run;
                else run = cnt[i];
            end
            total = cnt[n-1];
            if (total == 0) return r;
            prod = {48'd0, q} * {32'd0, total};
            rnk = prod[79:FRAC];
            b = n - 1;
            for (int i = 0; i + 1 < n; i++)
                if ({16'd0, cnt[i]} >= rnk) begin b = i; break; end
            if (b == n - 1) return bound_at(n - 2);
            if (b == 0 && (bkind[0] == KIND_MINF || bnd[0] <= 0)) return bound_at(0);
            start = 0;
            prev = 0;
            if (b > 0) begin
                if (bkind[b-1] != KIND_FIN) return r;
                start = bnd[b-1];
                prev = cnt[b-1];
            end
            den = cnt[b] - prev;
            num = rnk - prev;
            if (den == 0) return r;
            wdt = 64'(signed'(bnd[b])) - start;
            big = {64'd0, wdt} * {64'd0, num};
            big = big / {64'd0, den};
            r.kind = OUT_FIN;
            r.value = 48'(start + big[63:0]);
            return r;
        endfunction

        function void note_input(bucket_item_t it);
            if (it.present) insert(it.kind, it.bound, it.count);
            if (!it.last) return;
            pending = {pending, evaluate(it.q, it.q_nan)};
            used = 0; nan_seen = 0; ovf = 0;
        endfunction

        function void check_result(logic [47:0] v, logic [2:0] k);
            quantile_res_t e;
            results++;
            if (pending.size() == 0) begin
                $error("unexpected result value=%h kind=%0d", v, k);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind) begin
                $error("value_kind expected %0d actual %0d", e.kind, k);
                errors++;
            end
            if (v !== e.value) begin
                $error("value expected %h actual %h", e.value, v);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // bucket bound, bucket_count, quantile
    logic [3:0]   s_tuser;   // bucket_present, bound_kind, quantile_is_nan
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;   // value
    logic [2:0]   m_tuser;   // value_kind

    quantile_scoreboard sb;
    bit quiet;          // no idling in the final stretch
    int sent;

    histogram_bucket_quantile_unit uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("histogram_bucket_quantile_unit: mismatch");
        $finish;
    end

    // receiver with random stall bursts, sampling at the rising edge
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(bucket_item_t it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {it.q, it.count, it.bound};
        s_tuser  <= {it.q_nan, it.kind, it.present};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(it);
        sent++;
        @(negedge aclk);
    endtask

    function automatic bucket_item_t mk(logic [1:0] k, logic [47:0] b, logic [47:0] c);
        bucket_item_t it;
        it.present = 1; it.kind = k; it.bound = b; it.count = c;
        it.q = $urandom; it.q_nan = 1'($urandom); it.last = 0;
        return it;
    endfunction

    task automatic close_hist(logic [31:0] q, logic qn, logic pres);
        bucket_item_t it;
        it = mk(KIND_PINF, 48'({$urandom, $urandom}), 48'($urandom_range(0, 4)) << FRAC);
        it.present = pres; it.q = q; it.q_nan = qn; it.last = 1;
        send_item(it);
    endtask

    // histogram with random, sometimes malformed content and a quantile mostly in range
    task automatic random_hist();
        int nb;
        logic [47:0] acc;
        logic [31:0] q;
        bucket_item_t it;
        nb = $urandom_range(1, 6);
        acc = 0;
        for (int i = 0; i < nb; i++) begin
            acc = acc + (48'($urandom_range(0, 8)) << FRAC) + 48'($urandom_range(0, 3));
            it = mk(KIND_FIN, 48'(signed'($urandom_range(0, 40) - 10)) <<< FRAC, acc);
            case ($urandom_range(0, 19))
                0: it.kind = KIND_NAN;
                1: it.kind = KIND_MINF;
                2: it.bound = 48'({$urandom, $urandom});
                3: it.count = 48'({$urandom, $urandom});
                4: it.count = acc >> 2;
                default: ;
            endcase
            send_item(it);
        end
        case ($urandom_range(0, 9))
            0: q = $urandom;
            1: q = 32'h0001_0000;
            2: q = 0;
            default: q = $urandom_range(0, 32'h0001_0000);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            it = mk(KIND_FIN, 48'($urandom_range(1, 100)) << FRAC, acc);
            it.q = q; it.q_nan = 0; it.last = 1;
            send_item(it);
        end else
            close_hist(q, 1'($urandom_range(0, 15) == 0), 1'b1);
    endtask

    initial begin
        bucket_item_t it;
        sb = new();
        quiet = 0; sent = 0;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: nan, negative and above one quantiles, empty set, bare marker
        close_hist(32'h0000_8000, 1'b1, 1'b1);
        close_hist(32'h8000_0000, 1'b0, 1'b1);
        close_hist(32'h7FFF_FFFF, 1'b0, 1'b1);
        close_hist(32'h0000_8000, 1'b0, 1'b0);
        it = mk(KIND_FIN, 48'd0, 48'd0); it.present = 0; send_item(it);
        // nan bound, top not plus inf, single cell
        send_item(mk(KIND_NAN, 48'd5, 48'd1));
        close_hist(32'h0000_8000, 1'b0, 1'b1);
        it = mk(KIND_FIN, 48'h7FFF_FFFF_FFFF, CNT_MAX);
        it.q = 32'h0000_8000; it.q_nan = 0; it.last = 1; send_item(it);
        close_hist(32'h0000_8000, 1'b0, 1'b1);
        // minus inf first, saturating sum, extreme bounds, interpolation
        send_item(mk(KIND_MINF, 48'h8000_0000_0000, 48'd3 << FRAC));
        send_item(mk(KIND_FIN, 48'h8000_0000_0000, CNT_MAX));
        send_item(mk(KIND_FIN, 48'h8000_0000_0000, 48'd5));
        send_item(mk(KIND_FIN, 48'h7FFF_FFFF_FFFF, CNT_MAX));
        close_hist(32'h0000_0000, 1'b0, 1'b1);
        send_item(mk(KIND_FIN, 48'd10 << FRAC, 48'd4 << FRAC));
        send_item(mk(KIND_FIN, 48'd20 << FRAC, 48'd2 << FRAC));
        close_hist(32'h0000_C000, 1'b0, 1'b1);
        send_item(mk(KIND_FIN, 48'd7 << FRAC, 48'd0));
        close_hist(32'h0000_0000, 1'b0, 1'b1);
        // overflow: more distinct bounds than cells
        for (int i = 0; i < NCELLS + 1; i++)
            send_item(mk(KIND_FIN, 48'(i) << FRAC, 48'(i)));
        close_hist(32'h0000_8000, 1'b0, 1'b1);

        while (sent < 745) begin
            if (sent > 650) quiet = 1;
            if ($urandom_range(0, 9) == 0) begin
                it = mk(2'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
                it.present = 1'($urandom); it.last = $urandom_range(0, 3) == 0;
                send_item(it);
            end else
                random_hist();
        end
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("sent %0d bucket transfers, checked %0d quantile results", sent, sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("histogram_bucket_quantile_unit: match");
        else
            $display("histogram_bucket_quantile_unit: mismatch");
        $finish;
    end
endmodule
